FILE: design/pcm_pkg.sv
// pcm_pkg: shared types, widths, register indexes and reset values
// for the 4x5 rgba color matrix pipeline; no dependencies
`default_nettype none

package pcm_pkg;

  localparam int CHANNELS   = 4;
  localparam int PIX_W      = 8;
  localparam int WEIGHT_W   = 16;
  localparam int COEF_W     = CHANNELS * WEIGHT_W;
  localparam int OFFSET_W   = 32;
  localparam int PROD_W     = PIX_W + 1 + WEIGHT_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = OFFSET_W + 2;
  localparam int FRAC_W     = 8;
  localparam int STAGES     = 4;
  localparam int WORD_W     = CHANNELS * PIX_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(128);
  localparam logic [PIX_W-1:0] PIX_MAX    = '1;

  localparam logic [CFG_IDX_W-1:0] REG_RED_COEF     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_COEF   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_COEF    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_COEF   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_OFFSET  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_OFFSET = 4'd7;

  typedef logic [COEF_W-1:0]   coef_row_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [PIX_W-1:0]    pix_t;

  // identity matrix with zero offsets
  localparam coef_row_t COEF_RESET [CHANNELS] = '{
    64'h0000_0000_0000_0100,
    64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000,
    64'h0100_0000_0000_0000
  };

  typedef struct packed {
    logic [STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: design/pcm_cfg.sv
// pcm_cfg: matrix coefficient and offset registers behind the config write port
// depends on pcm_pkg
`default_nettype none

module pcm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pcm_pkg::coef_row_t                   coef   [pcm_pkg::CHANNELS],
  output pcm_pkg::offset_t                     offset [pcm_pkg::CHANNELS]
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcm_pkg::CHANNELS; i++) begin
        coef[i]   <= pcm_pkg::COEF_RESET[i];
        offset[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcm_pkg::REG_RED_COEF:     coef[0]   <= cfg_data;
        pcm_pkg::REG_GREEN_COEF:   coef[1]   <= cfg_data;
        pcm_pkg::REG_BLUE_COEF:    coef[2]   <= cfg_data;
        pcm_pkg::REG_ALPHA_COEF:   coef[3]   <= cfg_data;
        pcm_pkg::REG_RED_OFFSET:   offset[0] <= cfg_data[pcm_pkg::OFFSET_W-1:0];
        pcm_pkg::REG_GREEN_OFFSET: offset[1] <= cfg_data[pcm_pkg::OFFSET_W-1:0];
        pcm_pkg::REG_BLUE_OFFSET:  offset[2] <= cfg_data[pcm_pkg::OFFSET_W-1:0];
        pcm_pkg::REG_ALPHA_OFFSET: offset[3] <= cfg_data[pcm_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/pcm_ctrl.sv
// pcm_ctrl: valid bits and per-stage load enables for the four-stage pipeline
// depends on pcm_pkg
`default_nettype none

module pcm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output pcm_pkg::pipe_ctrl_t ctrl
);

  logic [pcm_pkg::STAGES-1:0] valid;
  logic [pcm_pkg::STAGES-1:0] load;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[pcm_pkg::STAGES-1] = !valid[pcm_pkg::STAGES-1] || m_tready;
    for (int i = pcm_pkg::STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < pcm_pkg::STAGES; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_tready  = load[0];
  assign m_tvalid  = valid[pcm_pkg::STAGES-1];
  assign ctrl.load = load;

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (rst)
    !valid[pcm_pkg::STAGES-1] |-> s_tready)
    else $error("input stalled while output stage empty");

  a_drain_takes_input: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  a_accept_fills_stage0: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> valid[0])
    else $error("accepted word not in first stage");

  a_stalled_word_moves_on: assert property (@(posedge clk) disable iff (rst)
    valid[pcm_pkg::STAGES-2] && !load[pcm_pkg::STAGES-2] |=> valid[pcm_pkg::STAGES-1])
    else $error("word lost under stall");

endmodule

`default_nettype wire

FILE: design/pcm_lane.sv
// pcm_lane: one output channel: products, pair sums, offset and round, clamp
// depends on pcm_pkg
`default_nettype none

module pcm_lane (
  input  wire logic                clk,
  input  wire pcm_pkg::pipe_ctrl_t ctrl,
  input  wire pcm_pkg::pix_t       px [pcm_pkg::CHANNELS],
  input  wire pcm_pkg::coef_row_t  coef,
  input  wire pcm_pkg::offset_t    offset,
  output pcm_pkg::pix_t            result
);

  logic signed [pcm_pkg::PROD_W-1:0] prod [pcm_pkg::CHANNELS];
  logic signed [pcm_pkg::PAIR_W-1:0] pair_lo;
  logic signed [pcm_pkg::PAIR_W-1:0] pair_hi;
  logic signed [pcm_pkg::SUM_W-1:0]  sum;
  logic signed [pcm_pkg::SUM_W-1:0]  sum_next;
  pcm_pkg::pix_t                     clamped;

  // stage 1: four 9x16 signed products
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      for (int k = 0; k < pcm_pkg::CHANNELS; k++) begin
        prod[k] <= pcm_pkg::PROD_W'($signed({1'b0, px[k]})
                   * $signed(coef[k*pcm_pkg::WEIGHT_W +: pcm_pkg::WEIGHT_W]));
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      pair_lo <= pcm_pkg::PAIR_W'(prod[0]) + pcm_pkg::PAIR_W'(prod[1]);
      pair_hi <= pcm_pkg::PAIR_W'(prod[2]) + pcm_pkg::PAIR_W'(prod[3]);
    end
  end

  // stage 3: total with offset and rounding bias
  assign sum_next = pcm_pkg::SUM_W'(pair_lo) + pcm_pkg::SUM_W'(pair_hi)
                  + pcm_pkg::SUM_W'($signed(offset)) + $signed(pcm_pkg::ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      sum <= sum_next;
    end
  end

  // stage 4: drop fraction and clamp to 0..255
  always_comb begin
    priority if (sum[pcm_pkg::SUM_W-1]) begin
      clamped = '0;
    end else if (|sum[pcm_pkg::SUM_W-2:pcm_pkg::FRAC_W+pcm_pkg::PIX_W]) begin
      clamped = pcm_pkg::PIX_MAX;
    end else begin
      clamped = sum[pcm_pkg::FRAC_W +: pcm_pkg::PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      result <= clamped;
    end
  end

endmodule

`default_nettype wire

FILE: design/pixel_color_matrix_4x5_top.sv
// pixel_color_matrix_4x5_top: rgba 4x5 color matrix stream filter
// depends on pcm_pkg, pcm_cfg, pcm_ctrl, pcm_lane
`default_nettype none

// One pixel enters per clock while s_tready is high; its result moves through
// the lane pipeline registers in order (multiply, pair add, offset and round,
// clamp); with the output side ready the block sustains one word per clock,
// and an output stall fills empty stages before it holds the input back.
// Each output channel is the dot product of r,g,b,a with its row of signed
// Q8.8 weights plus its signed offset in 1/256 units, rounded half up and
// clamped to 0..255. Registers reset to the identity matrix and are meant
// to be written only while no word is in flight; indexes above 7 are ignored.
module pixel_color_matrix_4x5_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // red_in, green_in, blue_in, alpha_in
  input  wire logic [pcm_pkg::WORD_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [pcm_pkg::WORD_W-1:0]           m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pcm_pkg::coef_row_t  coef   [pcm_pkg::CHANNELS];
  pcm_pkg::offset_t    offset [pcm_pkg::CHANNELS];
  pcm_pkg::pix_t       px     [pcm_pkg::CHANNELS];
  pcm_pkg::pix_t       result [pcm_pkg::CHANNELS];
  pcm_pkg::pipe_ctrl_t ctrl;

  pcm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .offset    (offset)
  );

  pcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  for (genvar c = 0; c < pcm_pkg::CHANNELS; c++) begin : g_lane
    assign px[c] = s_tdata[c*pcm_pkg::PIX_W +: pcm_pkg::PIX_W];
    assign m_tdata[c*pcm_pkg::PIX_W +: pcm_pkg::PIX_W] = result[c];

    pcm_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .px     (px),
      .coef   (coef[c]),
      .offset (offset[c]),
      .result (result[c])
    );
  end

endmodule

`default_nettype wire
